// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check prop at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- rtl/core/ncas_pkg.sv -----
// ----------------------------------------------------------------------------
// ncas_pkg
// Types, codes and helpers of the nested comment / code block scanner.
// ----------------------------------------------------------------------------
package ncas_pkg;

  localparam int DEPTH_BITS = 8;

  typedef logic [DEPTH_BITS-1:0] depth_t;
  localparam depth_t DEPTH_MAX = '1;
  localparam depth_t DEPTH_ONE = depth_t'(1);

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_LEAD     = 3'd1;
  localparam logic [2:0] MODE_CMT_OPEN = 3'd2;
  localparam logic [2:0] MODE_CMT      = 3'd3;
  localparam logic [2:0] MODE_BLK      = 3'd4;
  localparam logic [2:0] MODE_BLK_STR  = 3'd5;
  localparam logic [2:0] MODE_BLK_CMT  = 3'd6;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_OPEN = 2'd1;
  localparam logic [1:0] PEND_STAR = 2'd2;

  localparam logic [1:0] KIND_COMMENT = 2'd0;
  localparam logic [1:0] KIND_QUOTE   = 2'd1;
  localparam logic [1:0] KIND_BLOCK   = 2'd2;

  localparam int ALLOW_COMMENT = 0;
  localparam int ALLOW_QUOTE   = 1;
  localparam int ALLOW_BLOCK   = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic       str_open;
    logic [2:0] mode;
    logic [1:0] pend;
    logic       skip;
    depth_t     cdepth;
    depth_t     bdepth;
    logic [2:0] allow;
  } scan_state_t;

  typedef struct packed {
    logic       consumed;
    logic       skipped;
    logic       token_done;
    logic       found;
    logic [1:0] token_kind;
  } scan_res_t;

  typedef struct packed {
    logic [1:0] pend;
    depth_t     depth;
    logic       close;
  } cmt_step_t;

  typedef struct packed {
    scan_state_t st;
    scan_res_t   res;
  } scan_step_t;

  function automatic depth_t sat_inc(depth_t v);
    return (v == DEPTH_MAX) ? v : v + DEPTH_ONE;
  endfunction

  function automatic depth_t sat_dec(depth_t v);
    return (v == '0) ? v : v - DEPTH_ONE;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

// ----- rtl/core/ncas_in_if.sv -----
// ----------------------------------------------------------------------------
// ncas_in_if
// Byte request channel of the scanner: valid/ready plus one lookahead byte.
// ----------------------------------------------------------------------------
interface ncas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_req;
  logic       want_block;
  logic       want_quote;
  logic       want_comment;

  modport source (
    output valid, byte_in, start_req, want_block, want_quote, want_comment,
    input  ready
  );

  modport sink (
    input  valid, byte_in, start_req, want_block, want_quote, want_comment,
    output ready
  );
endinterface

// ----- rtl/core/ncas_out_if.sv -----
// ----------------------------------------------------------------------------
// ncas_out_if
// Result channel of the scanner: valid/ready plus per-byte scan status.
// ----------------------------------------------------------------------------
interface ncas_out_if;
  logic       valid;
  logic       ready;
  logic       consumed;
  logic       skipped;
  logic       token_done;
  logic       found;
  logic [1:0] token_kind;

  modport source (
    output valid, consumed, skipped, token_done, found, token_kind,
    input  ready
  );

  modport sink (
    input  valid, consumed, skipped, token_done, found, token_kind,
    output ready
  );
endinterface

// ----- rtl/core/ncas_step.sv -----
// ----------------------------------------------------------------------------
// ncas_step
// Next-state and result logic of the scanner for one lookahead byte.
// ----------------------------------------------------------------------------
module ncas_step import ncas_pkg::*; (
  input  scan_state_t cur,
  input  logic [7:0]  byte_in,
  input  logic        start_req,
  input  logic        want_block,
  input  logic        want_quote,
  input  logic        want_comment,
  output scan_state_t nxt,
  output scan_res_t   res
);

  function automatic cmt_step_t cmt_byte(logic [1:0] pend, depth_t d, logic [7:0] b);
    cmt_step_t r;
    logic      stop;
    r.pend  = pend;
    r.depth = d;
    r.close = 1'b0;
    stop    = 1'b0;
    if (pend == PEND_OPEN) begin
      r.pend = PEND_NONE;
      if (b == CH_STAR) begin
        r.depth = sat_inc(d);
        stop    = 1'b1;
      end
    end else if (pend == PEND_STAR) begin
      r.pend = PEND_NONE;
      if (b == CH_RPAREN) begin
        r.depth = sat_dec(d);
        r.close = (r.depth == '0);
        stop    = 1'b1;
      end
    end
    if (!stop) begin
      if (b == CH_LPAREN) begin
        r.pend = PEND_OPEN;
      end else if (b == CH_STAR) begin
        r.pend = PEND_STAR;
      end
    end
    return r;
  endfunction

  function automatic scan_step_t blk_byte(scan_state_t st, logic [7:0] b);
    scan_step_t r;
    logic       handled;
    r.st           = st;
    r.res          = '0;
    r.res.consumed = 1'b1;
    handled        = 1'b0;
    if (st.pend == PEND_OPEN) begin
      r.st.pend = PEND_NONE;
      if (b == CH_STAR) begin
        r.st.mode   = MODE_BLK_CMT;
        r.st.cdepth = DEPTH_ONE;
        handled     = 1'b1;
      end
    end
    if (!handled && st.skip) begin
      r.st.skip = 1'b0;
      handled   = 1'b1;
    end
    if (!handled) begin
      case (b)
        CH_LPAREN: r.st.pend = PEND_OPEN;
        CH_APOS:   r.st.skip = 1'b1;
        CH_DQUOTE: r.st.mode = MODE_BLK_STR;
        CH_LBRACE: r.st.bdepth = sat_inc(st.bdepth);
        CH_RBRACE: begin
          if (st.bdepth == DEPTH_ONE) begin
            r.st.mode          = MODE_IDLE;
            r.res.consumed     = 1'b0;
            r.res.token_done   = 1'b1;
            r.res.found        = 1'b1;
            r.res.token_kind   = KIND_BLOCK;
          end else begin
            r.st.bdepth = sat_dec(st.bdepth);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  scan_state_t s;
  scan_step_t  bs;
  cmt_step_t   cs;

  always_comb begin
    s   = cur;
    res = '0;
    bs  = '0;
    cs  = '0;
    if (start_req) begin
      s.allow  = {want_block, want_quote, want_comment};
      s.mode   = MODE_LEAD;
      s.pend   = PEND_NONE;
      s.skip   = 1'b0;
      s.cdepth = '0;
      s.bdepth = '0;
    end
    if (s.mode == MODE_IDLE || s.mode > MODE_BLK_CMT) begin
      s.mode = MODE_IDLE;
    end else if (byte_in == CH_NUL) begin
      res.token_done = 1'b1;
      if (s.mode == MODE_CMT) begin
        res.found      = 1'b1;
        res.token_kind = KIND_COMMENT;
      end else if (s.mode >= MODE_BLK ||
                   (s.mode == MODE_LEAD && s.allow[ALLOW_BLOCK])) begin
        res.found      = 1'b1;
        res.token_kind = KIND_BLOCK;
      end
      s.mode = MODE_IDLE;
      s.pend = PEND_NONE;
      s.skip = 1'b0;
    end else begin
      unique case (s.mode)
        MODE_LEAD: begin
          if (is_blank(byte_in)) begin
            res.consumed = 1'b1;
            res.skipped  = 1'b1;
          end else if (s.allow[ALLOW_BLOCK]) begin
            s.mode   = MODE_BLK;
            s.bdepth = DEPTH_ONE;
            bs       = blk_byte(s, byte_in);
            s        = bs.st;
            res      = bs.res;
          end else if (s.allow[ALLOW_QUOTE] && byte_in == CH_DQUOTE) begin
            s.str_open     = !s.str_open;
            s.mode         = MODE_IDLE;
            res.consumed   = 1'b1;
            res.token_done = 1'b1;
            res.found      = 1'b1;
            res.token_kind = KIND_QUOTE;
          end else if (!s.str_open && s.allow[ALLOW_COMMENT] &&
                       byte_in == CH_LPAREN) begin
            s.mode       = MODE_CMT_OPEN;
            res.consumed = 1'b1;
          end else begin
            s.mode         = MODE_IDLE;
            res.token_done = 1'b1;
          end
        end
        MODE_CMT_OPEN: begin
          if (byte_in == CH_STAR) begin
            s.mode       = MODE_CMT;
            s.cdepth     = DEPTH_ONE;
            res.consumed = 1'b1;
          end else begin
            s.mode         = MODE_IDLE;
            res.token_done = 1'b1;
          end
        end
        MODE_CMT: begin
          cs           = cmt_byte(s.pend, s.cdepth, byte_in);
          s.pend       = cs.pend;
          s.cdepth     = cs.depth;
          res.consumed = 1'b1;
          if (cs.close) begin
            s.mode         = MODE_IDLE;
            res.token_done = 1'b1;
            res.found      = 1'b1;
            res.token_kind = KIND_COMMENT;
          end
        end
        MODE_BLK: begin
          bs  = blk_byte(s, byte_in);
          s   = bs.st;
          res = bs.res;
        end
        MODE_BLK_STR: begin
          if (s.skip) begin
            s.skip = 1'b0;
          end else if (byte_in == CH_BSLASH) begin
            s.skip = 1'b1;
          end else if (byte_in == CH_DQUOTE) begin
            s.mode = MODE_BLK;
          end
          res.consumed = 1'b1;
        end
        MODE_BLK_CMT: begin
          cs       = cmt_byte(s.pend, s.cdepth, byte_in);
          s.pend   = cs.pend;
          s.cdepth = cs.depth;
          if (cs.close) begin
            s.mode = MODE_BLK;
          end
          res.consumed = 1'b1;
        end
        default: s.mode = MODE_IDLE;
      endcase
    end
    nxt = s;
  end

endmodule

// ----- rtl/core/ncas_out_reg.sv -----
// ----------------------------------------------------------------------------
// ncas_out_reg
// Result register: holds one scan result until the receiver takes it.
// ----------------------------------------------------------------------------
module ncas_out_reg import ncas_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  scan_res_t        res,
  output logic             free,
  ncas_out_if.source       out_ch
);

  logic      valid_r;
  logic      valid_nxt;
  scan_res_t res_r;

  assign free      = !valid_r || out_ch.ready;
  assign valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.consumed   = res_r.consumed;
  assign out_ch.skipped    = res_r.skipped;
  assign out_ch.token_done = res_r.token_done;
  assign out_ch.found      = res_r.found;
  assign out_ch.token_kind = res_r.token_kind;

endmodule

// ----- rtl/core/nested_comment_action_scanner_core.sv -----
// ----------------------------------------------------------------------------
// nested_comment_action_scanner_core
// Scans one token per request over a byte stream, one byte per request.
//
// in_ch carries one lookahead byte per request with start_req and the allowed
// token kinds; out_ch returns exactly one status per byte: consumed, skipped,
// token_done, found and token_kind. A byte with consumed 0 must be resent.
// Latency: a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the scan state updates in a
// single pass of logic between the scan state register and result register.
// in_ch.ready stays high while the result register is empty or being taken,
// so a stalled receiver holds one result and stops further bytes.
// Reset clears the scan state (idle, outside string, depths zero) and empties
// the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nested_comment_action_scanner_core import ncas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ncas_in_if.sink    in_ch,
  ncas_out_if.source out_ch
);

  scan_state_t state_r;
  scan_state_t state_nxt;
  scan_res_t   step_res;
  logic        free;
  logic        accept;

  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  ncas_step u_step (
    .cur          (state_r),
    .byte_in      (in_ch.byte_in),
    .start_req    (in_ch.start_req),
    .want_block   (in_ch.want_block),
    .want_quote   (in_ch.want_quote),
    .want_comment (in_ch.want_comment),
    .nxt          (state_nxt),
    .res          (step_res)
  );

  ncas_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .res    (step_res),
    .free   (free),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_accept_shows_result, accept |=> out_ch.valid)
  `ASSERT_CLK(a_skip_is_consumed,
    out_ch.valid && out_ch.skipped |-> out_ch.consumed && !out_ch.token_done)
  `ASSERT_CLK(a_kind_needs_found,
    out_ch.valid && !(out_ch.found && out_ch.token_done) |-> out_ch.token_kind == KIND_COMMENT)
  `ASSERT_CLK(a_block_depth_nonzero,
    state_r.mode == MODE_BLK || state_r.mode == MODE_BLK_STR ||
    state_r.mode == MODE_BLK_CMT |-> state_r.bdepth != '0)
  `ASSERT_CLK(a_comment_depth_nonzero,
    state_r.mode == MODE_CMT || state_r.mode == MODE_BLK_CMT |-> state_r.cdepth != '0)

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream check of the nested comment / code block scanner. A local
// model of the scan state predicts the status of every accepted byte, and
// each returned status is compared with the oldest prediction. Directed
// requests cover the token kinds and end cases, then depth saturation and
// a long receiver stall, then random request streams under three idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import ncas_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ncas_in_if  in_ch ();
  ncas_out_if out_ch ();

  nested_comment_action_scanner_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state as predicted
  logic       sc_in_str;
  logic [2:0] sc_mode;
  logic [1:0] sc_pend;
  logic       sc_skip;
  depth_t     sc_cdepth;
  depth_t     sc_bdepth;
  logic [2:0] sc_allow;

  scan_res_t exp_status_q[$];
  scan_res_t head_status;
  int        err_cnt = 0;
  int        busy_items = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        quiet_cycles = 0;
  int        hold_left = 0;
  logic      hold_req = 1'b0;

  function automatic depth_t depth_up(depth_t v);
    return (&v) ? v : depth_t'(v + 1'b1);
  endfunction

  function automatic depth_t depth_down(depth_t v);
    return (v == '0) ? v : depth_t'(v - 1'b1);
  endfunction

  function automatic logic blank_byte(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic scan_res_t status(logic c, logic s, logic d, logic f,
                                       logic [1:0] k);
    scan_res_t r;
    r.consumed   = c;
    r.skipped    = s;
    r.token_done = d;
    r.found      = f;
    r.token_kind = (f && d) ? k : '0;
    return r;
  endfunction

  function automatic logic nested_cmt_byte(logic [7:0] b);
    if (sc_pend == PEND_OPEN) begin
      sc_pend = PEND_NONE;
      if (b == CH_STAR) begin
        sc_cdepth = depth_up(sc_cdepth);
        return 1'b0;
      end
    end else if (sc_pend == PEND_STAR) begin
      sc_pend = PEND_NONE;
      if (b == CH_RPAREN) begin
        sc_cdepth = depth_down(sc_cdepth);
        return sc_cdepth == '0;
      end
    end
    if (b == CH_LPAREN) sc_pend = PEND_OPEN;
    else if (b == CH_STAR) sc_pend = PEND_STAR;
    return 1'b0;
  endfunction

  function automatic scan_res_t block_top_byte(logic [7:0] b);
    if (sc_pend == PEND_OPEN) begin
      sc_pend = PEND_NONE;
      if (b == CH_STAR) begin
        sc_mode   = MODE_BLK_CMT;
        sc_cdepth = depth_t'(1);
        return status(1'b1, 1'b0, 1'b0, 1'b0, '0);
      end
    end
    if (sc_skip) begin
      sc_skip = 1'b0;
      return status(1'b1, 1'b0, 1'b0, 1'b0, '0);
    end
    if (b == CH_LPAREN) sc_pend = PEND_OPEN;
    else if (b == CH_APOS) sc_skip = 1'b1;
    else if (b == CH_DQUOTE) sc_mode = MODE_BLK_STR;
    else if (b == CH_LBRACE) sc_bdepth = depth_up(sc_bdepth);
    else if (b == CH_RBRACE) begin
      if (sc_bdepth == depth_t'(1)) begin
        sc_mode = MODE_IDLE;
        return status(1'b0, 1'b0, 1'b1, 1'b1, KIND_BLOCK);
      end
      sc_bdepth = depth_down(sc_bdepth);
    end
    return status(1'b1, 1'b0, 1'b0, 1'b0, '0);
  endfunction

  function automatic scan_res_t predict_status(logic [7:0] b, logic st,
                                               logic wb, logic wq, logic wc);
    scan_res_t  r;
    logic [2:0] prev;
    if (st) begin
      sc_allow                = '0;
      sc_allow[ALLOW_COMMENT] = wc;
      sc_allow[ALLOW_QUOTE]   = wq;
      sc_allow[ALLOW_BLOCK]   = wb;
      sc_mode   = MODE_LEAD;
      sc_pend   = PEND_NONE;
      sc_skip   = 1'b0;
      sc_cdepth = '0;
      sc_bdepth = '0;
    end
    if (sc_mode == MODE_IDLE || sc_mode > MODE_BLK_CMT) begin
      sc_mode = MODE_IDLE;
      return status(1'b0, 1'b0, 1'b0, 1'b0, '0);
    end
    if (b == CH_NUL) begin
      prev    = sc_mode;
      sc_mode = MODE_IDLE;
      sc_pend = PEND_NONE;
      sc_skip = 1'b0;
      if (prev == MODE_CMT) return status(1'b0, 1'b0, 1'b1, 1'b1, KIND_COMMENT);
      if (prev >= MODE_BLK || (prev == MODE_LEAD && sc_allow[ALLOW_BLOCK]))
        return status(1'b0, 1'b0, 1'b1, 1'b1, KIND_BLOCK);
      return status(1'b0, 1'b0, 1'b1, 1'b0, '0);
    end
    r = status(1'b1, 1'b0, 1'b0, 1'b0, '0);
    case (sc_mode)
      MODE_LEAD: begin
        if (blank_byte(b)) begin
          r = status(1'b1, 1'b1, 1'b0, 1'b0, '0);
        end else if (sc_allow[ALLOW_BLOCK]) begin
          sc_mode   = MODE_BLK;
          sc_bdepth = depth_t'(1);
          r = block_top_byte(b);
        end else if (sc_allow[ALLOW_QUOTE] && b == CH_DQUOTE) begin
          sc_in_str = !sc_in_str;
          sc_mode   = MODE_IDLE;
          r = status(1'b1, 1'b0, 1'b1, 1'b1, KIND_QUOTE);
        end else if (!sc_in_str && sc_allow[ALLOW_COMMENT] && b == CH_LPAREN) begin
          sc_mode = MODE_CMT_OPEN;
        end else begin
          sc_mode = MODE_IDLE;
          r = status(1'b0, 1'b0, 1'b1, 1'b0, '0);
        end
      end
      MODE_CMT_OPEN: begin
        if (b == CH_STAR) begin
          sc_mode   = MODE_CMT;
          sc_cdepth = depth_t'(1);
        end else begin
          sc_mode = MODE_IDLE;
          r = status(1'b0, 1'b0, 1'b1, 1'b0, '0);
        end
      end
      MODE_CMT: begin
        if (nested_cmt_byte(b)) begin
          sc_mode = MODE_IDLE;
          r = status(1'b1, 1'b0, 1'b1, 1'b1, KIND_COMMENT);
        end
      end
      MODE_BLK: r = block_top_byte(b);
      MODE_BLK_STR: begin
        if (sc_skip) sc_skip = 1'b0;
        else if (b == CH_BSLASH) sc_skip = 1'b1;
        else if (b == CH_DQUOTE) sc_mode = MODE_BLK;
      end
      default: begin
        if (nested_cmt_byte(b)) sc_mode = MODE_BLK;
      end
    endcase
    return r;
  endfunction

  // send one byte request; starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic st,
                           input logic wb, input logic wq, input logic wc);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.byte_in      = b;
    in_ch.start_req    = st;
    in_ch.want_block   = wb;
    in_ch.want_quote   = wq;
    in_ch.want_comment = wc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (st || sc_mode != MODE_IDLE) busy_items++;
    exp_status_q.push_back(predict_status(b, st, wb, wq, wc));
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0, 1:    return CH_LBRACE;
      2, 3:    return CH_RBRACE;
      4:       return CH_LPAREN;
      5:       return CH_STAR;
      6:       return CH_RPAREN;
      7:       return CH_DQUOTE;
      8:       return CH_BSLASH;
      9:       return CH_APOS;
      10:      return CH_SPACE;
      11:      return 8'($urandom_range(8'hFF, 8'h01));
      12:      return ($urandom_range(2) == 0) ? CH_NUL : CH_TAB;
      default: return 8'($urandom_range(8'h7A, 8'h41));
    endcase
  endfunction

  task automatic send_stream(input logic [7:0] seq[$], input logic wb,
                             input logic wq, input logic wc);
    foreach (seq[i]) begin
      if (i == 0) send_byte(seq[i], 1'b1, wb, wq, wc);
      else send_byte(seq[i], 1'b0, 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_random_request();
    logic [7:0] seq[$];
    logic       wb, wq, wc;
    int         kind_sel;
    kind_sel = $urandom_range(9);
    wb = 1'($urandom);
    wq = 1'($urandom);
    wc = 1'($urandom);
    repeat ($urandom_range(2)) begin
      seq.push_back(($urandom_range(1) == 0) ? CH_SPACE :
                    8'(CH_TAB + $urandom_range(4)));
    end
    case (kind_sel)
      0: begin
        repeat ($urandom_range(8, 1)) begin
          send_byte(8'($urandom), 1'($urandom_range(3) == 0), 1'($urandom),
                    1'($urandom), 1'($urandom));
        end
        return;
      end
      1, 2, 3: begin
        wb = 1'b1;
        repeat ($urandom_range(12)) seq.push_back(pick_byte());
        repeat (3) seq.push_back(CH_RBRACE);
      end
      4, 5: begin
        wb = 1'b0;
        wc = 1'b1;
        seq.push_back(CH_LPAREN);
        seq.push_back(CH_STAR);
        repeat ($urandom_range(10)) seq.push_back(pick_byte());
        repeat ($urandom_range(3, 1)) begin
          seq.push_back(CH_STAR);
          seq.push_back(CH_RPAREN);
        end
      end
      6, 7: begin
        wb = 1'b0;
        wq = 1'b1;
        seq.push_back(CH_DQUOTE);
      end
      default: begin
        repeat ($urandom_range(6, 1)) seq.push_back(pick_byte());
      end
    endcase
    send_stream(seq, wb, wq, wc);
  endtask

  task automatic test_idle_and_no_match();
    send_byte("a", 1'b0, 1'b1, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_nested_comment();
    send_byte(CH_TAB, 1'b1, 1'b0, 1'b0, 1'b1);
    send_byte(CH_LPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_STAR, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_LPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_STAR, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_STAR, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_RPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_STAR, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_RPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
    // paren without star
    send_byte(CH_LPAREN, 1'b1, 1'b0, 1'b0, 1'b1);
    send_byte("x", 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_quote_toggle();
    send_byte(CH_DQUOTE, 1'b1, 1'b0, 1'b1, 1'b0);
    send_byte(CH_LPAREN, 1'b1, 1'b0, 1'b1, 1'b1);
    send_byte(CH_DQUOTE, 1'b1, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_code_block();
    send_byte(CH_LBRACE, 1'b1, 1'b1, 1'b1, 1'b1);
    send_byte(CH_DQUOTE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_DQUOTE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_DQUOTE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_APOS, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_end_and_restart();
    send_byte(CH_SPACE, 1'b1, 1'b1, 1'b0, 1'b0);
    send_byte(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_LPAREN, 1'b1, 1'b0, 1'b0, 1'b1);
    send_byte(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0);
    // abandon a block in progress
    send_byte(CH_LBRACE, 1'b1, 1'b1, 1'b0, 1'b0);
    send_byte(CH_DQUOTE, 1'b1, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_depth_saturation();
    send_byte(CH_LBRACE, 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (258) send_byte(CH_LBRACE, 1'b0, 1'b0, 1'b0, 1'b0);
    repeat (256) send_byte(CH_RBRACE, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_req     = 1'b1;
    send_byte(CH_LBRACE, 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (40) send_byte(pick_byte(), 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random(input int src_pct, input int snk_pct,
                             input int n_items);
    int base;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    base = busy_items;
    while (busy_items - base < n_items) send_random_request();
  endtask

  // receiver: random ready, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_status_q.size() == 0) begin
        $error("status with no byte outstanding");
        err_cnt++;
      end else begin
        head_status = exp_status_q.pop_front();
        if (out_ch.consumed !== head_status.consumed) begin
          $error("consumed: expected %0d, got %0d", head_status.consumed,
                 out_ch.consumed);
          err_cnt++;
        end
        if (out_ch.skipped !== head_status.skipped) begin
          $error("skipped: expected %0d, got %0d", head_status.skipped,
                 out_ch.skipped);
          err_cnt++;
        end
        if (out_ch.token_done !== head_status.token_done) begin
          $error("token_done: expected %0d, got %0d", head_status.token_done,
                 out_ch.token_done);
          err_cnt++;
        end
        if (out_ch.found !== head_status.found) begin
          $error("found: expected %0d, got %0d", head_status.found,
                 out_ch.found);
          err_cnt++;
        end
        if (out_ch.token_kind !== head_status.token_kind) begin
          $error("token_kind: expected %0d, got %0d", head_status.token_kind,
                 out_ch.token_kind);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.byte_in      = '0;
    in_ch.start_req    = 1'b0;
    in_ch.want_block   = 1'b0;
    in_ch.want_quote   = 1'b0;
    in_ch.want_comment = 1'b0;
    out_ch.ready       = 1'b0;
    sc_in_str = 1'b0;
    sc_mode   = MODE_IDLE;
    sc_pend   = PEND_NONE;
    sc_skip   = 1'b0;
    sc_cdepth = '0;
    sc_bdepth = '0;
    sc_allow  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    src_idle_pct = 13;
    snk_idle_pct = 84;
    test_idle_and_no_match();
    test_nested_comment();
    test_quote_toggle();
    test_code_block();
    test_end_and_restart();
    test_depth_saturation();
    test_backpressure();
    test_random(13, 84, 40);
    test_random(84, 13, 40);
    test_random(0, 0, 40);

    in_ch.valid = 1'b0;
    while (exp_status_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
